// ===== sv/hsi_pkg.sv =====
// shared types and constants of the sphere indenter node force block
// no dependencies
package hsi_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_3D       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS   = 3'd6;

    localparam logic [46:0] FMAG_MAX = {47{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQ,
        S_ROOT,
        S_RP,
        S_SROOT,
        S_PS,
        S_KH,
        S_KP,
        S_SCALE,
        S_FD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== sv/hsi_if.sv =====
// channel interfaces: node input, force result, register write
// depends on hsi_pkg for the register index width
interface hsi_node_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic               has_mass;
    logic [31:0]        node_groups;
    logic               is_local;
    logic               last_node;
    modport source (output valid, node_x, node_y, node_z, has_mass, node_groups, is_local,
                    last_node, input ready);
    modport sink (input valid, node_x, node_y, node_z, has_mass, node_groups, is_local,
                  last_node, output ready);
endinterface

interface hsi_force_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               in_contact;
    logic signed [63:0] total_x;
    logic signed [63:0] total_y;
    logic signed [63:0] total_z;
    logic [31:0]        contact_total;
    logic               pass_done;
    modport source (output valid, force_x, force_y, force_z, in_contact, total_x, total_y,
                    total_z, contact_total, pass_done, input ready);
    modport sink (input valid, force_x, force_y, force_z, in_contact, total_x, total_y,
                  total_z, contact_total, pass_done, output ready);
endinterface

interface hsi_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hsi_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/hsi_mul.sv =====
// bit-serial shift-add multiplier, 48 x 32 bits, one multiplier bit per cycle
// no dependencies
module hsi_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [79:0] o_prod
);
    logic [47:0] r_a;
    logic [79:0] r_p;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] n_hi;

    assign n_hi = {1'b0, r_p[79:32]} + (r_p[0] ? {1'b0, r_a} : 49'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {48'd0, i_b};
        end else if (r_busy) begin
            r_p <= {n_hi, r_p[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// ===== sv/hsi_sqrt.sv =====
// bit-serial floor square root of a 64 bit value, one root bit per cycle
// no dependencies
module hsi_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_val;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem2;
    logic [35:0] trial;

    assign rem2  = {r_rem[33:0], r_val[63:62]};
    assign trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[61:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== sv/hsi_div.sv =====
// restoring bit-serial divider, 80 bit dividend whose top 32 bits are below
// the divisor, 48 bit quotient, one quotient bit per cycle; no dependencies
module hsi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [79:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [47:0] r_lo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] t;
    logic        q_bit;

    assign t     = {r_rem, r_lo[47]};
    assign q_bit = (t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[79:48];
            r_lo  <= i_num[47:0];
        end else if (r_busy) begin
            r_rem <= q_bit ? 32'(t - {1'b0, r_den}) : t[31:0];
            r_lo  <= {r_lo[46:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;
endmodule

// ===== sv/hertz_sphere_indent_node_force.sv =====
// top level of the sphere indenter node force block: register file, sequencer,
// running totals and output register; uses hsi_pkg, hsi_if, hsi_mul, hsi_sqrt, hsi_div
//
//   port     dir  role
//   i_node   in   one grid node per transaction
//   o_force  out  force, contact flag and running totals per node
//   i_cfg    in   register writes, index and data
//
// one node at a time; a node outside the gate skips the units, a contact runs
// through the bit-serial multiplier, root and divider units in turn
// (3 squares, 1 root in 2D or 2 in 3D, 1 product in 2D or 3 in 3D, then
// 3 scaled components of one product and one division each); a new node is taken while
// the previous result waits in the output register; reset clears totals and registers and selects 3D mode
module hertz_sphere_indent_node_force #(
    parameter int COUNT_WIDTH = hsi_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsi_node_if.sink   i_node,
    hsi_force_if.source o_force,
    hsi_cfg_if.sink    i_cfg
);
    import hsi_pkg::*;

    // registers
    logic [30:0]        r_radius;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [31:0]        r_k;
    logic               r_3d;
    logic [31:0]        r_grp;

    t_state             r_state, n_state;
    logic signed [32:0] r_dx, r_dy, r_dz;
    logic [30:0]        r_ax, r_ay, r_az;
    logic               r_gate, r_yzero, r_local, r_last;
    logic [63:0]        r_acc;
    logic [31:0]        r_r, r_p, r_s;
    logic [45:0]        r_h;
    logic [46:0]        r_fmag;
    logic [1:0]         r_idx;
    logic               r_busy;
    logic               r_hit;
    logic signed [47:0] r_f [3];
    logic signed [63:0] r_tot [3];
    logic signed [63:0] r_sum [3];
    logic [COUNT_WIDTH-1:0] r_count;

    logic               r_oval;
    logic signed [47:0] r_ofx, r_ofy, r_ofz;
    logic               r_ohit;
    logic signed [63:0] r_otx, r_oty, r_otz;
    logic [31:0]        r_ocnt;
    logic               r_olast;

    // unit hookup
    logic        mul_start, mul_done;
    logic [47:0] mul_a;
    logic [31:0] mul_b;
    logic [79:0] mul_prod;
    logic        sq_start, sq_done;
    logic [63:0] sq_val;
    logic [31:0] sq_root;
    logic        dv_start, dv_done;
    logic [47:0] dv_quot;

    logic        node_acc;
    logic        unit_done;
    logic        out_free;
    logic [32:0] abs_x, abs_y, abs_z;
    logic        pre_ok;
    logic [30:0] sel_a;
    logic        sel_neg;
    logic signed [47:0] f_signed;
    logic signed [63:0] f_ext, tot_sel, tot_add;
    logic [63:0] cnt_ext;
    logic [COUNT_WIDTH-1:0] n_count;

    hsi_mul u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_prod)
    );
    hsi_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_start(sq_start), .i_val(sq_val),
        .o_done(sq_done), .o_root(sq_root)
    );
    hsi_div u_div (
        .i_clk, .i_rst_n, .i_start(dv_start), .i_num(mul_prod), .i_den(r_r),
        .o_done(dv_done), .o_quot(dv_quot)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_node.ready = (r_state == S_IDLE);
    assign node_acc     = i_node.valid && (r_state == S_IDLE);
    assign out_free     = !r_oval || o_force.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_k      <= '0;
            r_3d     <= 1'b1;
            r_grp    <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RADIUS:   r_radius <= i_cfg.data[30:0];
                CFG_CENTER_X: r_cx     <= i_cfg.data;
                CFG_CENTER_Y: r_cy     <= i_cfg.data;
                CFG_CENTER_Z: r_cz     <= i_cfg.data;
                CFG_STIFF:    r_k      <= i_cfg.data;
                CFG_3D:       r_3d     <= i_cfg.data[0];
                CFG_GROUPS:   r_grp    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // absolute offsets and the box test
    assign abs_x  = r_dx[32] ? 33'(-r_dx) : r_dx;
    assign abs_y  = r_dy[32] ? 33'(-r_dy) : r_dy;
    assign abs_z  = r_dz[32] ? 33'(-r_dz) : r_dz;
    assign pre_ok = r_gate && (abs_x < {2'b00, r_radius}) && (abs_y < {2'b00, r_radius})
                    && (abs_z < {2'b00, r_radius});

    always_comb begin
        case (r_idx)
            2'd0:    begin sel_a = r_ax; sel_neg = r_dx[32]; end
            2'd1:    begin sel_a = r_ay; sel_neg = r_dy[32]; end
            default: begin sel_a = r_az; sel_neg = r_dz[32]; end
        endcase
    end

    assign f_signed = sel_neg ? 48'(-dv_quot) : dv_quot;
    assign f_ext    = 64'(f_signed);
    assign tot_sel  = r_tot[r_idx];
    assign tot_add  = tot_sel + f_ext;

    assign unit_done = mul_done || sq_done || dv_done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_node.valid) n_state = S_CHECK;
            S_CHECK: n_state = pre_ok ? S_SQ : S_DONE;
            S_SQ:    if (mul_done && r_idx == 2'd2) n_state = S_ROOT;
            S_ROOT: begin
                if (sq_done) begin
                    if (sq_root >= {1'b0, r_radius}) n_state = S_DONE;
                    else n_state = r_3d ? S_RP : S_KP;
                end
            end
            S_RP:    if (mul_done) n_state = S_SROOT;
            S_SROOT: if (sq_done) n_state = S_PS;
            S_PS:    if (mul_done) n_state = S_KH;
            S_KH:    if (mul_done) n_state = S_SCALE;
            S_KP:    if (mul_done) n_state = S_SCALE;
            S_SCALE: n_state = (r_r == '0) ? S_DONE : S_FD;
            S_FD:    if (mul_done) n_state = S_DIV;
            S_DIV:   if (dv_done) n_state = (r_idx == 2'd2) ? S_DONE : S_FD;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit starts and operands
    always_comb begin
        mul_start = 1'b0;
        sq_start  = 1'b0;
        dv_start  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        sq_val    = r_acc;
        case (r_state)
            S_SQ: begin
                mul_start = !r_busy;
                mul_a     = {17'd0, sel_a};
                mul_b     = {1'b0, sel_a};
            end
            S_ROOT, S_SROOT: sq_start = !r_busy;
            S_RP: begin
                mul_start = !r_busy;
                mul_a     = {17'd0, r_radius};
                mul_b     = r_p;
            end
            S_PS: begin
                mul_start = !r_busy;
                mul_a     = {16'd0, r_p};
                mul_b     = r_s;
            end
            S_KH: begin
                mul_start = !r_busy;
                mul_a     = {2'b00, r_h};
                mul_b     = r_k;
            end
            S_KP: begin
                mul_start = !r_busy;
                mul_a     = {16'd0, r_p};
                mul_b     = r_k;
            end
            S_FD: begin
                mul_start = !r_busy;
                mul_a     = {1'b0, r_fmag};
                mul_b     = {1'b0, sel_a};
            end
            S_DIV:   dv_start = !r_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_start || sq_start || dv_start) r_busy <= 1'b1;
            else if (unit_done) r_busy <= 1'b0;
        end
    end

    assign cnt_ext = 64'(r_count);
    assign n_count = (r_hit && r_count != '1) ? r_count + 1'b1 : r_count;

    // datapath
    always_ff @(posedge i_clk) begin
        if (node_acc) begin
            r_dx    <= 33'(i_node.node_x) - 33'(r_cx);
            r_dy    <= 33'(i_node.node_y) - 33'(r_cy);
            r_dz    <= r_3d ? 33'(i_node.node_z) - 33'(r_cz) : 33'd0;
            r_gate  <= i_node.has_mass && ((i_node.node_groups & r_grp) != '0);
            r_yzero <= (i_node.node_y == '0);
            r_local <= i_node.is_local;
            r_last  <= i_node.last_node;
        end
        case (r_state)
            S_CHECK: begin
                r_ax  <= abs_x[30:0];
                r_ay  <= abs_y[30:0];
                r_az  <= abs_z[30:0];
                r_acc <= '0;
                r_idx <= '0;
                r_hit <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_f[i]   <= '0;
                    r_tot[i] <= r_sum[i];
                end
            end
            S_SQ: begin
                if (mul_done) begin
                    r_acc <= r_acc + mul_prod[63:0];
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            S_ROOT: begin
                if (sq_done) begin
                    r_r   <= sq_root;
                    r_p   <= {1'b0, r_radius} - sq_root;
                    r_hit <= (sq_root < {1'b0, r_radius});
                end
            end
            S_RP:    if (mul_done) r_acc <= mul_prod[63:0];
            S_SROOT: if (sq_done) r_s <= sq_root;
            S_PS:    if (mul_done) r_h <= mul_prod[61:16];
            S_KH: begin
                if (mul_done) begin
                    r_fmag <= (mul_prod[79:63] != '0) ? FMAG_MAX : mul_prod[62:16];
                end
            end
            S_KP:    if (mul_done) r_fmag <= mul_prod[62:16];
            S_SCALE: if (r_yzero) r_fmag <= {1'b0, r_fmag[46:1]};
            S_DIV: begin
                if (dv_done) begin
                    r_f[r_idx] <= f_signed;
                    // saturating add of a local force
                    if (r_local) begin
                        if (!tot_sel[63] && !f_ext[63] && tot_add[63])
                            r_tot[r_idx] <= {1'b0, {63{1'b1}}};
                        else if (tot_sel[63] && f_ext[63] && !tot_add[63])
                            r_tot[r_idx] <= {1'b1, 63'd0};
                        else
                            r_tot[r_idx] <= tot_add;
                    end
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // running totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval  <= 1'b0;
            r_count <= '0;
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_oval <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                    for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                end else begin
                    r_count <= n_count;
                    for (int i = 0; i < 3; i++) r_sum[i] <= r_tot[i];
                end
            end else if (o_force.valid && o_force.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ofx   <= r_f[0];
            r_ofy   <= r_f[1];
            r_ofz   <= r_f[2];
            r_ohit  <= r_hit;
            r_otx   <= r_tot[0];
            r_oty   <= r_tot[1];
            r_otz   <= r_tot[2];
            r_ocnt  <= (64'(n_count) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(64'(n_count));
            r_olast <= r_last;
        end
    end

    assign o_force.valid         = r_oval;
    assign o_force.force_x       = r_ofx;
    assign o_force.force_y       = r_ofy;
    assign o_force.force_z       = r_ofz;
    assign o_force.in_contact    = r_ohit;
    assign o_force.total_x       = r_otx;
    assign o_force.total_y       = r_oty;
    assign o_force.total_z       = r_otz;
    assign o_force.contact_total = (cnt_ext == 64'd0 && r_ocnt == 32'd0) ? 32'd0 : r_ocnt;
    assign o_force.pass_done     = r_olast;
endmodule

// ===== bench/hsi_tb_pkg.sv =====
// contact force predictor and expected-result store for the sphere indenter bench
// depends on hsi_pkg for register indexes and the force limit
package hsi_tb_pkg;
    import hsi_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               has_mass;
        logic [31:0]        groups;
        logic               is_local;
        logic               last;
    } t_node;

    typedef struct packed {
        logic signed [47:0] fx;
        logic signed [47:0] fy;
        logic signed [47:0] fz;
        logic               contact;
        logic signed [63:0] tx;
        logic signed [63:0] ty;
        logic signed [63:0] tz;
        logic [31:0]        count;
        logic               done;
    } t_force;

    class contact_scoreboard;
        logic [30:0]        radius;
        logic signed [31:0] cx, cy, cz;
        logic [31:0]        stiff;
        logic               mode3d;
        logic [31:0]        gsel;
        logic signed [63:0] acc_x, acc_y, acc_z;
        logic [31:0]        hits;
        t_force             pending[$];
        int                 errors;

        function new();
            radius = '0; cx = '0; cy = '0; cz = '0; stiff = '0; mode3d = 1'b1; gsel = '0;
            acc_x = '0; acc_y = '0; acc_z = '0; hits = '0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                CFG_RADIUS:   radius = d[30:0];
                CFG_CENTER_X: cx = d;
                CFG_CENTER_Y: cy = d;
                CFG_CENTER_Z: cz = d;
                CFG_STIFF:    stiff = d;
                CFG_3D:       mode3d = d[0];
                CFG_GROUPS:   gsel = d;
                default: ;
            endcase
        endfunction

        static function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        static function logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                    logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return s[63:0];
        endfunction

        static function logic signed [47:0] component(logic [63:0] fmag,
                                                      logic signed [63:0] d,
                                                      logic [63:0] r);
            logic [127:0] q;
            logic [63:0]  ad;
            ad = d < 0 ? -d : d;
            q = (128'(fmag) * 128'(ad)) / 128'(r);
            return d < 0 ? -q[47:0] : q[47:0];
        endfunction

        function void note_node(t_node n);
            logic signed [63:0] dx, dy, dz;
            logic [63:0]  ax, ay, az, rr, sq, r, p, s, h, fmag;
            logic [127:0] kh;
            t_force       e;
            dx = 64'(n.x) - 64'(cx);
            dy = 64'(n.y) - 64'(cy);
            dz = mode3d ? 64'(n.z) - 64'(cz) : 64'sd0;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            az = dz < 0 ? -dz : dz;
            rr = 64'(radius);
            e = '0;
            if (n.has_mass && (n.groups & gsel) != 0 && ax < rr && ay < rr && az < rr) begin
                sq = ax * ax + ay * ay + az * az;
                if (sq < rr * rr) begin
                    r = floor_root(sq);
                    p = rr - r;
                    e.contact = 1'b1;
                    if (mode3d) begin
                        s = floor_root(rr * p);
                        h = (p * s) >> 16;
                        kh = (128'(stiff) * 128'(h)) >> 16;
                        fmag = kh > 128'(FMAG_MAX) ? 64'(FMAG_MAX) : kh[63:0];
                    end else begin
                        fmag = (64'(stiff) * p) >> 16;
                    end
                    if (n.y == 0) fmag >>= 1;
                    if (r != 0) begin
                        e.fx = component(fmag, dx, r);
                        e.fy = component(fmag, dy, r);
                        e.fz = component(fmag, dz, r);
                    end
                    if (hits != '1) hits++;
                    if (n.is_local) begin
                        acc_x = sat_sum(acc_x, 64'(e.fx));
                        acc_y = sat_sum(acc_y, 64'(e.fy));
                        acc_z = sat_sum(acc_z, 64'(e.fz));
                    end
                end
            end
            e.tx = acc_x; e.ty = acc_y; e.tz = acc_z;
            e.count = hits;
            e.done = n.last;
            if (n.last) begin
                acc_x = '0; acc_y = '0; acc_z = '0; hits = '0;
            end
            pending.push_back(e);
        endfunction

        function void check_force(t_force a);
            t_force e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected force transaction, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.fx !== e.fx) report("force_x", e.fx, a.fx);
            if (a.fy !== e.fy) report("force_y", e.fy, a.fy);
            if (a.fz !== e.fz) report("force_z", e.fz, a.fz);
            if (a.contact !== e.contact) report("in_contact", e.contact, a.contact);
            if (a.tx !== e.tx) report("total_x", e.tx, a.tx);
            if (a.ty !== e.ty) report("total_y", e.ty, a.ty);
            if (a.tz !== e.tz) report("total_z", e.tz, a.tz);
            if (a.count !== e.count) report("contact_total", e.count, a.count);
            if (a.done !== e.done) report("pass_done", e.done, a.done);
        endfunction

        function void report(string f, logic [63:0] e, logic [63:0] a);
            $display("%0t: %s mismatch, expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction
    endclass
endpackage

// ===== bench/hsi_tb.sv =====
// top of the sphere indenter bench: drives nodes and register writes, checks forces
// depends on hsi_pkg, hsi_if, hsi_tb_pkg and the block under test
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsi_pkg::*;
    import hsi_tb_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    hsi_node_if  node_ch();
    hsi_force_if force_ch();
    hsi_cfg_if   cfg_ch();

    contact_scoreboard sb = new();
    bit calm;
    bit hold_off;
    bit stim_done;
    int idle_cycles;

    always #2 i_clk = ~i_clk;

    hertz_sphere_indent_node_force dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_node(node_ch.sink), .o_force(force_ch.source), .i_cfg(cfg_ch.sink)
    );

    initial begin
        node_ch.valid = 1'b0;
        node_ch.node_x = '0; node_ch.node_y = '0; node_ch.node_z = '0;
        node_ch.has_mass = 1'b0; node_ch.node_groups = '0;
        node_ch.is_local = 1'b0; node_ch.last_node = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        force_ch.ready = 1'b0;
    end

    // result side: random stalls, long hold-off on request
    always @(negedge i_clk) begin
        force_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        if (force_ch.valid && force_ch.ready) begin
            sb.check_force('{force_ch.force_x, force_ch.force_y, force_ch.force_z,
                             force_ch.in_contact, force_ch.total_x, force_ch.total_y,
                             force_ch.total_z, force_ch.contact_total,
                             force_ch.pass_done});
        end
        if ((node_ch.valid && node_ch.ready) || (force_ch.valid && force_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_node(t_node n);
        while (!calm && $urandom_range(99) < 18) @(negedge i_clk);
        node_ch.node_x <= n.x; node_ch.node_y <= n.y; node_ch.node_z <= n.z;
        node_ch.has_mass <= n.has_mass; node_ch.node_groups <= n.groups;
        node_ch.is_local <= n.is_local; node_ch.last_node <= n.last;
        node_ch.valid = 1'b1;
        do @(posedge i_clk); while (!node_ch.ready);
        sb.note_node(n);
        @(negedge i_clk);
        node_ch.valid = 1'b0;
    endtask

    // wait for all results, then let the sequencer settle before a register write
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [31:0] near(logic signed [31:0] c, logic [30:0] rad);
        logic signed [63:0] v;
        v = 64'(c) + $signed(64'($urandom_range(2 * rad + 2))) - 64'(rad) - 1;
        if ($urandom_range(9) == 0) return $urandom;
        return v[31:0];
    endfunction

    function automatic t_node rand_node(logic signed [31:0] c0, logic signed [31:0] c1,
                                        logic signed [31:0] c2, logic [30:0] rad);
        t_node n;
        n.x = near(c0, rad);
        n.y = $urandom_range(7) == 0 ? 32'sd0 : near(c1, rad);
        n.z = near(c2, rad);
        n.has_mass = $urandom_range(9) != 0;
        n.groups = $urandom_range(4) == 0 ? $urandom : 32'h1 << $urandom_range(31);
        n.is_local = $urandom_range(3) != 0;
        n.last = $urandom_range(40) == 0;
        return n;
    endfunction

    task automatic setup(logic [30:0] rad, logic [31:0] c0, logic [31:0] c1,
                         logic [31:0] c2, logic [31:0] k, logic m3, logic [31:0] g);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_CENTER_X, c0);
        write_reg(CFG_CENTER_Y, c1);
        write_reg(CFG_CENTER_Z, c2);
        write_reg(CFG_STIFF, k);
        write_reg(CFG_3D, m3);
        write_reg(CFG_GROUPS, g);
    endtask

    initial begin
        logic [30:0] rad;
        logic [31:0] c0, c1, c2;
        t_node n;
        calm = 1'b0; hold_off = 1'b0; stim_done = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset-state node, center, axes, symmetry plane, extremes
        send_node('{32'sd100, 32'sd0, 32'sd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0});
        drain();
        setup(31'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
              32'h0010_0000, 1'b1, 32'h0000_0005);
        send_node('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b1, 32'h1, 1'b1, 1'b0});
        send_node('{32'sh0002_0000, 32'sd0, 32'sh0000_8000, 1'b1, 32'h4, 1'b1, 1'b0});
        send_node('{32'sh0002_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b1, 32'h4, 1'b0, 1'b0});
        send_node('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0003_8000, 1'b1, 32'h1, 1'b1, 1'b0});
        send_node('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0003_7FFF, 1'b1, 32'h1, 1'b1, 1'b0});
        send_node('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b0, 32'h1, 1'b1, 1'b0});
        send_node('{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000, 1'b1, 32'h2, 1'b1, 1'b0});
        send_node('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'hFFFF_FFFF,
                    1'b1, 1'b1});
        drain();
        setup(31'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
              32'h0010_0000, 1'b0, 32'hFFFF_FFFF);
        send_node('{32'sh0000_0000, 32'shFFFF_8000, 32'sh8000_0000, 1'b1, 32'h8000_0000,
                    1'b1, 1'b0});
        send_node('{32'sh0002_0000, 32'sd0, 32'sh1234_0000, 1'b1, 32'h1, 1'b1, 1'b1});
        drain();
        // largest radius and stiffness, center at the corners: saturation
        setup(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_node('{32'sh8000_0000 + i, 32'sh7FFF_FFFF - i, 32'sh8000_0000 + 32'sh1000_0000 * i,
                        1'b1, 32'hFFFF_FFFF, 1'b1, i == 7});
        drain();
        write_reg(CFG_RADIUS, 31'd0);
        send_node('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'hFFFF_FFFF,
                    1'b1, 1'b1});
        drain();

        // random phases with varied settings
        for (int ph = 0; ph < 12; ph++) begin
            rad = ph % 4 == 0 ? 31'h7FFF_FFFF : 31'($urandom_range(32'h0040_0000, 1));
            c0 = $urandom; c1 = $urandom; c2 = $urandom;
            if (ph % 3 == 1) begin c0 = 32'sh7FFF_FFFF; c1 = 32'sh8000_0000; end
            setup(rad, c0, c1, c2, ph % 5 == 0 ? 32'hFFFF_FFFF : $urandom, ph[0],
                  $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom);
            calm = ph == 5;
            for (int i = 0; i < 150; i++) begin
                if (ph == 3 && i == 20) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (3000) @(negedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                n = rand_node(c0, c1, c2, rad);
                if (i == 149) n.last = 1'b1;
                send_node(n);
            end
            calm = 1'b0;
            drain();
        end

        stim_done = 1'b1;
        repeat (500) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
